/* sv/damc_pkg.sv */
// damc_pkg: shared entry type, command codes and helper functions
// for the dual address map cache; no dependencies
package damc_pkg;

	localparam logic [2:0] CMD_LKP_PHYS = 3'd0;
	localparam logic [2:0] CMD_LKP_STR  = 3'd1;
	localparam logic [2:0] CMD_UPDATE   = 3'd2;
	localparam logic [2:0] CMD_INVAL    = 3'd3;
	localparam logic [2:0] CMD_MARK_RES = 3'd4;
	localparam logic [2:0] CMD_MARK_NR  = 3'd5;

	localparam int LINE_SHIFT = 6;

	typedef struct packed {
		logic        valid;
		logic        resident;
		logic [47:0] phys;
		logic [31:0] str;
		logic [31:0] stamp;
	} entry_t;

	function automatic logic [47:0] entry_key(input entry_t e, input logic byphys);
		logic [47:0] k;
		k = byphys ? e.phys : {16'd0, e.str};
		return k;
	endfunction

	// stamp first, key breaks ties
	function automatic logic entry_older(input entry_t a, input entry_t b,
		input logic byphys);
		logic [79:0] ka;
		logic [79:0] kb;
		ka = {a.stamp, entry_key(a, byphys)};
		kb = {b.stamp, entry_key(b, byphys)};
		return ka < kb;
	endfunction

endpackage

/* sv/damc_table.sv */
// damc_table: one set-row memory of the dual address map cache with a
// clearing sweep after reset; depends on damc_pkg
module damc_table #(
	parameter int ROWS = 256,
	parameter int WAYS = 16,
	parameter int IW   = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [IW-1:0]                   rd_idx,
	output damc_pkg::entry_t [WAYS-1:0]     rd_data,
	input  logic                            wr_en,
	input  logic [IW-1:0]                   wr_idx,
	input  damc_pkg::entry_t [WAYS-1:0]     wr_data,
	output logic                            clr_busy
);

	localparam logic [IW-1:0] LAST_ROW = IW'(ROWS - 1);

	damc_pkg::entry_t [WAYS-1:0] mem [ROWS];
	damc_pkg::entry_t [WAYS-1:0] rd_q;
	logic                        clr_q;
	logic [IW-1:0]               clr_idx_q;

	// sweep every row to invalid after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == LAST_ROW) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_idx];
		end
	end

	assign rd_data  = rd_q;
	assign clr_busy = clr_q;

endmodule

/* sv/damc_scan.sv */
// damc_scan: walks the ways of one set a way per cycle, finding the hit,
// the first free way and the victim; depends on damc_pkg
module damc_scan #(
	parameter int WAYS = 16,
	parameter int WW   = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  damc_pkg::entry_t [WAYS-1:0] row,
	input  logic                        byphys,
	input  logic [47:0]                 key,
	output logic                        done,
	output logic                        hit,
	output logic [WW-1:0]               hit_way,
	output damc_pkg::entry_t            hit_e,
	output logic                        free,
	output logic [WW-1:0]               free_way,
	output logic [WW-1:0]               vic_way,
	output damc_pkg::entry_t            vic_e
);

	localparam logic [WW-1:0] LAST_WAY = WW'(WAYS - 1);

	damc_pkg::entry_t [WAYS-1:0] sh_q;
	logic                        run_q;
	logic                        done_q;
	logic [WW-1:0]               cnt_q;
	logic                        hit_q, free_q, ntr_f_q;
	logic [WW-1:0]               hit_way_q, free_way_q, ntr_way_q, all_way_q;
	damc_pkg::entry_t            hit_e_q, ntr_e_q, all_e_q;
	damc_pkg::entry_t            cur;

	assign cur = sh_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_WAY) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q    <= row;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			ntr_f_q <= 1'b0;
		end else if (run_q) begin
			for (int i = 0; i < WAYS - 1; i++) begin
				sh_q[i] <= sh_q[i+1];
			end
			if (!hit_q && cur.valid && damc_pkg::entry_key(cur, byphys) == key) begin
				hit_q     <= 1'b1;
				hit_way_q <= cnt_q;
				hit_e_q   <= cur;
			end
			if (!free_q && !cur.valid) begin
				free_q     <= 1'b1;
				free_way_q <= cnt_q;
			end
			if (!cur.resident && (!ntr_f_q || damc_pkg::entry_older(cur, ntr_e_q, byphys)))
			begin
				ntr_f_q   <= 1'b1;
				ntr_way_q <= cnt_q;
				ntr_e_q   <= cur;
			end
			if (cnt_q == '0 || damc_pkg::entry_older(cur, all_e_q, byphys)) begin
				all_way_q <= cnt_q;
				all_e_q   <= cur;
			end
		end
	end

	assign done     = done_q;
	assign hit      = hit_q;
	assign hit_way  = hit_way_q;
	assign hit_e    = hit_e_q;
	assign free     = free_q;
	assign free_way = free_way_q;
	assign vic_way  = ntr_f_q ? ntr_way_q : all_way_q;
	assign vic_e    = ntr_f_q ? ntr_e_q : all_e_q;

endmodule

/* sv/dual_address_map_cache.sv */
// dual address map cache: a lookup, or a mark that misses, is one table pass;
// update, invalidate and a mark that hits take two passes; unused commands give
// their result beat in the cycle after they are accepted. a pass is a read, a load
// and a way-per-cycle scan; busy drops in the result cycle, so the next command can
// be accepted at the edge that ends the beat. after reset both tables are swept
// invalid, one row a cycle, with busy high; the result side cannot stall
module dual_address_map_cache #(
	parameter int SET_CNT  = 256,
	parameter int NUM_WAYS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [47:0] phys_addr,
	input  logic [31:0] struct_addr,
	output logic        done,
	output logic        found,
	output logic [47:0] mapped_addr,
	output logic        ev_ps_valid,
	output logic [47:0] ev_ps_phys,
	output logic [31:0] ev_ps_struct,
	output logic        ev_sp_valid,
	output logic [47:0] ev_sp_phys,
	output logic [31:0] ev_sp_struct
);

	// set index bits: largest power of two not above SET_CNT
	localparam int SB   = $clog2(SET_CNT + 1) - 1;
	localparam int ROWS = 1 << SB;
	localparam int IW   = (SB > 0) ? SB : 1;
	localparam int WW   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam logic [IW-1:0] IDX_MASK = IW'(ROWS - 1);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_LD   = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;

	logic [2:0]  state_q;
	logic [2:0]  cmd_q;
	logic [47:0] phys_q;
	logic [31:0] str_q;
	logic [31:0] key_str_q;   // structural key of a structural-side pass
	logic        tsel_q;      // 0 physical side, 1 structural side
	logic [31:0] stamp_q;
	logic        done_q;

	logic        found_q;
	logic [47:0] mapped_q;
	logic        evp_v_q, evs_v_q;
	logic [47:0] evp_phys_q, evs_phys_q;
	logic [31:0] evp_str_q, evs_str_q;

	damc_pkg::entry_t [NUM_WAYS-1:0] row_q;
	damc_pkg::entry_t [NUM_WAYS-1:0] ps_rd, sp_rd, wdata;
	logic          ps_clr, sp_clr;
	logic [IW-1:0] ps_idx, sp_idx, idx;
	logic          accept;

	// scan results
	logic             sc_done, sc_hit, sc_free;
	logic [WW-1:0]    sc_hit_way, sc_free_way, sc_vic_way;
	damc_pkg::entry_t sc_hit_e, sc_vic_e;
	logic [47:0]      sc_key;

	// write-back decision
	logic             we;
	logic [WW-1:0]    wr_way;
	damc_pkg::entry_t wr_e;
	logic             mark_flag;

	assign accept    = start && (state_q == S_IDLE);
	assign ps_idx    = IW'(phys_q[damc_pkg::LINE_SHIFT +: IW]) & IDX_MASK;
	assign sp_idx    = IW'(key_str_q) & IDX_MASK;
	assign idx       = tsel_q ? sp_idx : ps_idx;
	assign sc_key    = tsel_q ? {16'd0, key_str_q} : phys_q;
	assign mark_flag = (cmd_q == damc_pkg::CMD_MARK_RES);

	damc_table #(.ROWS(ROWS), .WAYS(NUM_WAYS), .IW(IW)) u_ps_tbl (
		.clk(clk), .arst_n(arst_n),
		.rd_en(state_q == S_RD && !tsel_q), .rd_idx(idx), .rd_data(ps_rd),
		.wr_en(we && !tsel_q), .wr_idx(idx), .wr_data(wdata),
		.clr_busy(ps_clr)
	);

	damc_table #(.ROWS(ROWS), .WAYS(NUM_WAYS), .IW(IW)) u_sp_tbl (
		.clk(clk), .arst_n(arst_n),
		.rd_en(state_q == S_RD && tsel_q), .rd_idx(idx), .rd_data(sp_rd),
		.wr_en(we && tsel_q), .wr_idx(idx), .wr_data(wdata),
		.clr_busy(sp_clr)
	);

	damc_scan #(.WAYS(NUM_WAYS), .WW(WW)) u_scan (
		.clk(clk), .arst_n(arst_n),
		.load(state_q == S_LD),
		.row(tsel_q ? sp_rd : ps_rd),
		.byphys(!tsel_q), .key(sc_key),
		.done(sc_done), .hit(sc_hit), .hit_way(sc_hit_way), .hit_e(sc_hit_e),
		.free(sc_free), .free_way(sc_free_way),
		.vic_way(sc_vic_way), .vic_e(sc_vic_e)
	);

	// what the finished scan writes back into the set
	always_comb begin
		we     = 1'b0;
		wr_way = sc_hit_way;
		wr_e   = sc_hit_e;
		if (state_q == S_SCAN && sc_done) begin
			case (cmd_q)
				damc_pkg::CMD_LKP_PHYS, damc_pkg::CMD_LKP_STR: begin
					we         = sc_hit;
					wr_e.stamp = stamp_q;
				end
				damc_pkg::CMD_UPDATE: begin
					we          = 1'b1;
					wr_way      = sc_hit ? sc_hit_way : (sc_free ? sc_free_way : sc_vic_way);
					wr_e.valid  = 1'b1;
					wr_e.resident = sc_hit ? sc_hit_e.resident : 1'b0;
					wr_e.phys   = phys_q;
					wr_e.str    = str_q;
					wr_e.stamp  = stamp_q;
				end
				damc_pkg::CMD_INVAL: begin
					we   = sc_hit;
					wr_e = '0;
				end
				damc_pkg::CMD_MARK_RES, damc_pkg::CMD_MARK_NR: begin
					we            = sc_hit;
					wr_e.resident = mark_flag;
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			wdata[w] = (WW'(w) == wr_way) ? wr_e : row_q[w];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			tsel_q  <= 1'b0;
			stamp_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					if (!ps_clr && !sp_clr) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						tsel_q <= (cmd == damc_pkg::CMD_LKP_STR);
						if (cmd inside {damc_pkg::CMD_LKP_PHYS, damc_pkg::CMD_LKP_STR}) begin
							if (stamp_q != '1) begin
								stamp_q <= stamp_q + 1'b1;
							end
						end
						if (cmd inside {[damc_pkg::CMD_LKP_PHYS : damc_pkg::CMD_MARK_NR]}) begin
							state_q <= S_RD;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_RD: begin
					state_q <= S_LD;
				end
				S_LD: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sc_done) begin
						// second pass on the structural side, or finish
						if (!tsel_q && (cmd_q inside {damc_pkg::CMD_UPDATE,
							damc_pkg::CMD_INVAL} || (cmd_q inside
							{damc_pkg::CMD_MARK_RES, damc_pkg::CMD_MARK_NR} && sc_hit)))
						begin
							tsel_q  <= 1'b1;
							state_q <= S_RD;
						end else begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command payload and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= cmd;
			phys_q     <= phys_addr;
			str_q      <= struct_addr;
			key_str_q  <= struct_addr;
			found_q    <= 1'b0;
			mapped_q   <= '0;
			evp_v_q    <= 1'b0;
			evp_phys_q <= '0;
			evp_str_q  <= '0;
			evs_v_q    <= 1'b0;
			evs_phys_q <= '0;
			evs_str_q  <= '0;
		end
		if (state_q == S_LD) begin
			row_q <= tsel_q ? sp_rd : ps_rd;
		end
		if (state_q == S_SCAN && sc_done) begin
			case (cmd_q)
				damc_pkg::CMD_LKP_PHYS: begin
					found_q  <= sc_hit;
					mapped_q <= sc_hit ? {16'd0, sc_hit_e.str} : 48'd0;
				end
				damc_pkg::CMD_LKP_STR: begin
					found_q  <= sc_hit;
					mapped_q <= sc_hit ? sc_hit_e.phys : 48'd0;
				end
				damc_pkg::CMD_UPDATE: begin
					if (!sc_hit && !sc_free) begin
						if (tsel_q) begin
							evs_v_q    <= 1'b1;
							evs_phys_q <= sc_vic_e.phys;
							evs_str_q  <= sc_vic_e.str;
						end else begin
							evp_v_q    <= 1'b1;
							evp_phys_q <= sc_vic_e.phys;
							evp_str_q  <= sc_vic_e.str;
						end
					end
				end
				damc_pkg::CMD_MARK_RES, damc_pkg::CMD_MARK_NR: begin
					if (!tsel_q && sc_hit) begin
						found_q   <= 1'b1;
						key_str_q <= sc_hit_e.str;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign found        = found_q;
	assign mapped_addr  = mapped_q;
	assign ev_ps_valid  = evp_v_q;
	assign ev_ps_phys   = evp_phys_q;
	assign ev_ps_struct = evp_str_q;
	assign ev_sp_valid  = evs_v_q;
	assign ev_sp_phys   = evs_phys_q;
	assign ev_sp_struct = evs_str_q;

`ifndef SYNTHESIS
	// a result beat only follows work or an accepted command
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_SCAN) || $past(state_q == S_IDLE && start))
		else $error("result beat without a command");
	// tables are written only in the write-back cycle of a scan
	a_one_wr: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q == S_SCAN && sc_done)
		else $error("table write outside the write-back cycle");
	// the stamp counter never goes backward
	a_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		stamp_q >= $past(stamp_q))
		else $error("stamp went backward");
	// no command while the tables are being swept
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(ps_clr || sp_clr) |-> busy)
		else $error("ready during clearing sweep");
`endif

endmodule
